// ===== rtl/core/ppm_pkg.sv =====
// ----------------------------------------------------------------------------
// ppm_pkg
// Shared widths, item codes, register indexes and types of the PWM meter.
// ----------------------------------------------------------------------------
package ppm_pkg;

  localparam int COUNT_BITS_DEFAULT = 32;
  localparam int WORD_BITS          = 32;
  localparam int DUTY_BITS          = 10;
  localparam int MODE_BITS          = 3;
  localparam int LOST_BITS          = 8;
  localparam int CFG_INDEX_BITS     = 3;

  // Item kinds
  localparam logic [MODE_BITS-1:0] MODE_RISE    = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_FALL    = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_UNKNOWN = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_LOST    = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_TICK    = 3'd4;
  localparam logic [MODE_BITS-1:0] MODE_CLEAR   = 3'd5;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_PERIOD   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_INTERVAL = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_PULSE    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TIMEOUT_MS   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TIMER_RATE   = 3'd4;

  // Register reset values
  localparam logic [WORD_BITS-1:0] RST_MIN_PERIOD   = 32'd2;
  localparam logic [WORD_BITS-1:0] RST_MAX_INTERVAL = 32'd10000000;
  localparam logic [WORD_BITS-1:0] RST_MIN_PULSE    = 32'd1;
  localparam logic [WORD_BITS-1:0] RST_TIMEOUT_MS   = 32'd1000;
  localparam logic [WORD_BITS-1:0] RST_TIMER_RATE   = 32'd1000000;

  localparam logic [DUTY_BITS-1:0] PERMILLE = 10'd1000;

  typedef struct packed {
    logic [WORD_BITS-1:0] min_period;
    logic [WORD_BITS-1:0] max_interval;
    logic [WORD_BITS-1:0] min_pulse;
    logic [WORD_BITS-1:0] timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] period;
    logic [WORD_BITS-1:0] pulse;
    logic [WORD_BITS-1:0] last_edge;
    logic [WORD_BITS-1:0] errors;
    logic                 period_ok;
    logic                 pulse_ok;
    logic                 timed_out;
  } meas_t;

endpackage

// ===== rtl/core/ppm_serial_div.sv =====
// ----------------------------------------------------------------------------
// ppm_serial_div
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ppm_serial_div import ppm_pkg::*; #(
  parameter int QUOT_BITS = WORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] rem_init,      // must be below divisor
  input  logic [QUOT_BITS-1:0] dividend_low,
  input  logic [WORD_BITS-1:0] divisor,
  output logic [QUOT_BITS-1:0] quotient,
  output logic                 done
);

  localparam int CntW = $clog2(QUOT_BITS + 1);

  logic [WORD_BITS-1:0] rem;
  logic [WORD_BITS-1:0] div_r;
  logic [QUOT_BITS-1:0] shreg;
  logic [CntW-1:0]      cnt;
  logic [WORD_BITS:0]   trial;
  logic [WORD_BITS:0]   diff;
  logic                 take;

  // Shift the next dividend bit into the remainder; quotient bits fill from the bottom
  assign trial    = {rem, shreg[QUOT_BITS-1]};
  assign diff     = trial - {1'b0, div_r};
  assign take     = (trial >= {1'b0, div_r});
  assign quotient = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CntW'(QUOT_BITS);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt <= cnt - CntW'(1);
      if (cnt == CntW'(1)) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= rem_init;
      shreg <= dividend_low;
      div_r <= divisor;
    end else if (cnt != '0) begin
      rem   <= take ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
      shreg <= {shreg[QUOT_BITS-2:0], take};
    end
  end

endmodule

// ===== rtl/core/ppm_meas.sv =====
// ----------------------------------------------------------------------------
// ppm_meas
// Measurement state: period, pulse width, timeout and error count update.
// ----------------------------------------------------------------------------
module ppm_meas import ppm_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [MODE_BITS-1:0] mode,
  input  logic [WORD_BITS-1:0] capture_tick,
  input  logic [WORD_BITS-1:0] now_ms,
  input  logic [LOST_BITS-1:0] lost_count,
  input  cfg_t                 cfg,
  output meas_t                meas,
  output logic                 done
);

  localparam logic [WORD_BITS-1:0] TickMask = (COUNT_BITS >= WORD_BITS) ? '1 :
      WORD_BITS'((64'd1 << COUNT_BITS) - 64'd1);

  // Item held for the update
  logic [MODE_BITS-1:0] mode_r;
  logic [WORD_BITS-1:0] tick_r;
  logic [WORD_BITS-1:0] now_r;
  logic [LOST_BITS-1:0] lost_r;

  // Phase marker: difference, compare, update
  logic [2:0] run;

  // State
  logic [WORD_BITS-1:0] last_rise,  last_rise_next;
  logic                 seen_rise,  seen_rise_next;
  logic [WORD_BITS-1:0] period,     period_next;
  logic                 period_ok,  period_ok_next;
  logic [WORD_BITS-1:0] pulse,      pulse_next;
  logic                 pulse_ok,   pulse_ok_next;
  logic [WORD_BITS-1:0] last_edge,  last_edge_next;
  logic                 timed_out,  timed_out_next;
  logic [WORD_BITS-1:0] errors,     errors_next;

  logic [WORD_BITS:0]   d_raw;
  logic [WORD_BITS-1:0] diff_r;
  logic [WORD_BITS-1:0] elapsed_r;
  logic                 p_in_r, w_in_r, w_gt_r, expire_r;
  logic [LOST_BITS-1:0] inc;
  logic [WORD_BITS:0]   err_sum;
  logic                 pulse_good;

  assign d_raw = {1'b0, tick_r} - {1'b0, last_rise};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= '0;
    end else begin
      run <= {run[1:0], start};
    end
  end

  assign done = run[2];

  always_ff @(posedge clk) begin
    if (start) begin
      mode_r <= mode;
      tick_r <= capture_tick & TickMask;
      now_r  <= now_ms;
      lost_r <= lost_count;
    end
    if (run[0]) begin
      // Saturate a difference that wraps beyond the word
      if (COUNT_BITS > WORD_BITS && d_raw[WORD_BITS]) begin
        diff_r <= '1;
      end else begin
        diff_r <= d_raw[WORD_BITS-1:0] & TickMask;
      end
      elapsed_r <= now_r - last_edge;
    end
    if (run[1]) begin
      p_in_r   <= (diff_r >= cfg.min_period) && (diff_r <= cfg.max_interval);
      w_in_r   <= (diff_r >= cfg.min_pulse) && (diff_r <= cfg.max_interval);
      w_gt_r   <= (diff_r > period);
      expire_r <= !seen_rise || (elapsed_r > cfg.timeout_ms);
    end
  end

  assign pulse_good = w_in_r && !(period_ok && w_gt_r);
  assign err_sum    = {1'b0, errors} + (WORD_BITS + 1)'(inc);

  always_comb begin
    last_rise_next = last_rise;
    seen_rise_next = seen_rise;
    period_next    = period;
    period_ok_next = period_ok;
    pulse_next     = pulse;
    pulse_ok_next  = pulse_ok;
    last_edge_next = last_edge;
    timed_out_next = timed_out;
    inc            = '0;
    unique case (mode_r)
      MODE_RISE: begin
        last_edge_next = now_r;
        timed_out_next = 1'b0;
        if (seen_rise) begin
          period_next    = diff_r;
          period_ok_next = p_in_r;
          inc            = LOST_BITS'(!p_in_r);
        end
        last_rise_next = tick_r;
        seen_rise_next = 1'b1;
      end
      MODE_FALL: begin
        last_edge_next = now_r;
        timed_out_next = 1'b0;
        if (!seen_rise) begin
          // Orphan falling edge: keep the old width
          pulse_ok_next = 1'b0;
          inc           = LOST_BITS'(1);
        end else begin
          pulse_next    = diff_r;
          pulse_ok_next = pulse_good;
          inc           = LOST_BITS'(!pulse_good);
        end
      end
      MODE_UNKNOWN: begin
        last_edge_next = now_r;
        timed_out_next = 1'b0;
        inc            = LOST_BITS'(1);
      end
      MODE_LOST: begin
        inc = lost_r;
      end
      MODE_TICK: begin
        if (expire_r) begin
          timed_out_next = 1'b1;
          period_ok_next = 1'b0;
          pulse_ok_next  = 1'b0;
        end
      end
      MODE_CLEAR: begin
        last_rise_next = '0;
        seen_rise_next = 1'b0;
        period_next    = '0;
        period_ok_next = 1'b0;
        pulse_next     = '0;
        pulse_ok_next  = 1'b0;
        last_edge_next = '0;
        timed_out_next = 1'b0;
      end
      default: begin
      end
    endcase
    if (mode_r == MODE_CLEAR) begin
      errors_next = '0;
    end else if (err_sum[WORD_BITS]) begin
      errors_next = '1;
    end else begin
      errors_next = err_sum[WORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_rise <= '0;
      seen_rise <= 1'b0;
      period    <= '0;
      period_ok <= 1'b0;
      pulse     <= '0;
      pulse_ok  <= 1'b0;
      last_edge <= '0;
      timed_out <= 1'b0;
      errors    <= '0;
    end else if (run[2]) begin
      last_rise <= last_rise_next;
      seen_rise <= seen_rise_next;
      period    <= period_next;
      period_ok <= period_ok_next;
      pulse     <= pulse_next;
      pulse_ok  <= pulse_ok_next;
      last_edge <= last_edge_next;
      timed_out <= timed_out_next;
      errors    <= errors_next;
    end
  end

  assign meas.period    = period;
  assign meas.pulse     = pulse;
  assign meas.last_edge = last_edge;
  assign meas.errors    = errors;
  assign meas.period_ok = period_ok;
  assign meas.pulse_ok  = pulse_ok;
  assign meas.timed_out = timed_out;

endmodule

// ===== rtl/core/pwm_period_pulse_capture_meter.sv =====
// ----------------------------------------------------------------------------
// pwm_period_pulse_capture_meter
// PWM period, pulse width and duty meter fed by timestamped edge items.
// ----------------------------------------------------------------------------
// Usage: each item on the slave stream carries an edge or control kind in
// s_tuser and the capture tick, millisecond time and lost count in s_tdata.
// Every item yields exactly one snapshot item on the master stream: the
// measured values in m_tdata and the validity flags in m_tuser.
// Path from acceptance to m_tvalid: the state update (difference, compare,
// update), preparation (ST_PREP, ST_START), the bit-serial frequency
// division (one quotient bit per cycle; the duty division runs alongside),
// a step that sees both quotients finish, and the load of the output
// register, which waits while the output is not free.
// Only one item is in work at a time: s_tready is high only while no item
// is in work, and rises as the output register is loaded.
// A finished snapshot waiting in the output register does not
// block the next item; that item's result waits until the register is taken.
// Reset: rst clears the measurement state, the error count and both streams,
// and loads the register defaults. A clear item resets the measurement
// state and the error count but keeps the registers.
// Configuration: cfg_we writes cfg_data to register cfg_index at once;
// indexes beyond the list are ignored. Write only while idle.
// ----------------------------------------------------------------------------
module pwm_period_pulse_capture_meter import ppm_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  // Slave stream
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [71:0]               s_tdata,   // capture_tick, now_ms, lost_count
  input  logic [MODE_BITS-1:0]      s_tuser,   // mode
  // Master stream
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [175:0]              m_tdata,   // period, pulse_width, last_edge_ms,
                                               // error_count, frequency_hz,
                                               // duty_permille, zero fill
  output logic [3:0]                m_tuser,   // period_ok, pulse_ok, timed_out,
                                               // all_valid
  // Configuration writes
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [WORD_BITS-1:0]      cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MEAS  = 3'd1;
  localparam logic [2:0] ST_PREP  = 3'd2;
  localparam logic [2:0] ST_START = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  localparam int ProdBits = WORD_BITS + DUTY_BITS;

  logic [2:0] state, state_next;

  cfg_t                 cfg;
  logic [WORD_BITS-1:0] timer_rate;

  meas_t                meas;
  logic                 meas_done;
  logic                 accept;

  logic [ProdBits-1:0]  prod_r;
  logic                 all_r;
  logic                 zero_r;
  logic                 sat_r;
  logic                 div_start;

  logic [WORD_BITS-1:0] freq_q;
  logic                 freq_done;
  logic [DUTY_BITS-1:0] duty_q;
  logic                 duty_done;

  logic [WORD_BITS-1:0] freq_out;
  logic [DUTY_BITS-1:0] duty_out;
  logic                 load_out;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (state == ST_IDLE);
  assign div_start = (state == ST_START);
  assign load_out  = (state == ST_OUT) && (!m_tvalid || m_tready);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_period   <= RST_MIN_PERIOD;
      cfg.max_interval <= RST_MAX_INTERVAL;
      cfg.min_pulse    <= RST_MIN_PULSE;
      cfg.timeout_ms   <= RST_TIMEOUT_MS;
      timer_rate       <= RST_TIMER_RATE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_PERIOD:   cfg.min_period   <= cfg_data;
        CFG_MAX_INTERVAL: cfg.max_interval <= cfg_data;
        CFG_MIN_PULSE:    cfg.min_pulse    <= cfg_data;
        CFG_TIMEOUT_MS:   cfg.timeout_ms   <= cfg_data;
        CFG_TIMER_RATE:   timer_rate       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ppm_meas #(
    .COUNT_BITS (COUNT_BITS)
  ) u_meas (
    .clk          (clk),
    .rst          (rst),
    .start        (accept),
    .mode         (s_tuser),
    .capture_tick (s_tdata[31:0]),
    .now_ms       (s_tdata[63:32]),
    .lost_count   (s_tdata[71:64]),
    .cfg          (cfg),
    .meas         (meas),
    .done         (meas_done)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_MEAS;
      ST_MEAS:  if (meas_done) state_next = ST_PREP;
      ST_PREP:  state_next = ST_START;
      ST_START: state_next = ST_DIV;
      ST_DIV:   if (freq_done && duty_done) state_next = ST_OUT;
      ST_OUT:   if (load_out) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Prepare the divisions: the pulse scaled to permille, and the cases that
  // need no quotient (invalid snapshot, zero period, pulse not below period)
  always_ff @(posedge clk) begin
    if (state == ST_PREP) begin
      prod_r <= ProdBits'(meas.pulse) * ProdBits'(PERMILLE);
      all_r  <= meas.period_ok && meas.pulse_ok && !meas.timed_out;
      zero_r <= (meas.period == '0);
      sat_r  <= (meas.pulse >= meas.period);
    end
  end

  ppm_serial_div #(
    .QUOT_BITS (WORD_BITS)
  ) u_freq_div (
    .clk          (clk),
    .rst          (rst),
    .start        (div_start),
    .rem_init     ('0),
    .dividend_low (timer_rate),
    .divisor      (meas.period),
    .quotient     (freq_q),
    .done         (freq_done)
  );

  // Pulse below period keeps the quotient under 1024, so the top bits of
  // the scaled pulse already form a remainder below the divisor
  ppm_serial_div #(
    .QUOT_BITS (DUTY_BITS)
  ) u_duty_div (
    .clk          (clk),
    .rst          (rst),
    .start        (div_start),
    .rem_init     (prod_r[ProdBits-1:DUTY_BITS]),
    .dividend_low (prod_r[DUTY_BITS-1:0]),
    .divisor      (meas.period),
    .quotient     (duty_q),
    .done         (duty_done)
  );

  always_comb begin
    if (!all_r || zero_r) begin
      freq_out = '0;
      duty_out = '0;
    end else begin
      freq_out = freq_q;
      duty_out = sat_r ? PERMILLE : duty_q;
    end
  end

  // Output register: hold the snapshot until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {6'd0, duty_out, freq_out, meas.errors, meas.last_edge,
                  meas.pulse, meas.period};
      m_tuser <= {all_r, meas.timed_out, meas.pulse_ok, meas.period_ok};
    end
  end

endmodule
